// ===== sv/tvdllfw_pkg.sv =====
// Shared types and constants for the limited-linear TVD face weight core.
// Used by the front end, the divider, the back end and the top level.
package tvdllfw_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int QBITS          = 27;
    localparam int GAIN_W         = 23;
    localparam int WGT_W          = 17;
    localparam int RQ_W           = 29;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 23'd131072;
    localparam logic [25:0]       SAT_SCALE  = 26'd65536000;
    localparam logic signed [RQ_W-1:0] RQ_SAT_POS = 29'sd131006464;
    localparam logic signed [RQ_W-1:0] RQ_SAT_NEG = -29'sd131137536;
    localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;

    typedef struct packed {
        logic              sat;
        logic              sat_pos;
        logic              qneg;
        logic              up;
        logic [WGT_W-1:0]  cw;
    } t_side;

endpackage

// ===== sv/tvd_limited_linear_face_weight_core.sv =====
// Top level of the limited-linear TVD face weight core.
// Instantiates tvdllfw_front, tvdllfw_div and tvdllfw_back; uses tvdllfw_pkg.
//
// One mesh face enters per transfer on the slave stream and one weight pair
// leaves per transfer on the master stream, in order.
// The limiter gain is written through i_cfg_we / i_cfg_wdata; the user must
// do so only while idle, as the core itself does not enforce it. There are
// three front-end stages (products, dot sum and threshold, compare and
// numerator), 27 divider stages (one quotient bit each), and two back-end
// stages (gain product, clamp and blend). Throughput is one face per cycle
// unless the receiver stalls; every stage is a register with a valid bit,
// so the divider is fully pipelined. Reset clears all valid bits and loads
// the gain with two in Q7.16. When the receiver stalls with a result
// waiting, the whole pipeline holds, o_s_tready drops and no item is lost or
// repeated; empty stages stay empty until the stall ends.
module tvd_limited_linear_face_weight_core #(
    parameter int VALUE_BITS = tvdllfw_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // Fields from bit 0: value_step, grad_owner_x/y/z, grad_neigh_x/y/z,
    // delta_x/y/z, face_flux, central_weight, zero padding.
    input  logic [((11*VALUE_BITS+17+7)/8)*8-1:0] i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // Fields from bit 0: face_weight, limiter_value, zero padding.
    output logic [39:0]                        o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [tvdllfw_pkg::GAIN_W-1:0]     i_cfg_wdata
);
    localparam int VB   = VALUE_BITS;
    localparam int NUMW = (2*VB + 2 > VB + 28) ? 2*VB + 2 : VB + 28;
    localparam int WW   = tvdllfw_pkg::WGT_W;

    logic [tvdllfw_pkg::GAIN_W-1:0] r_gain;
    logic                           en;
    logic signed [VB-1:0]           go [3], gn [3], dl [3];
    logic                           f_vld, d_vld;
    logic [NUMW-1:0]                f_num;
    logic [VB-1:0]                  f_den;
    tvdllfw_pkg::t_side             f_side, d_side;
    logic [tvdllfw_pkg::QBITS-1:0]  d_q;
    logic [WW-1:0]                  b_w, b_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= tvdllfw_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    for (genvar k = 0; k < 3; k++) begin : g_fld
        assign go[k] = i_s_tdata[(1+k)*VB +: VB];
        assign gn[k] = i_s_tdata[(4+k)*VB +: VB];
        assign dl[k] = i_s_tdata[(7+k)*VB +: VB];
    end

    tvdllfw_front #(.VALUE_BITS(VB), .NUMW(NUMW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_step  (i_s_tdata[0 +: VB]),
        .i_go    (go),
        .i_gn    (gn),
        .i_dl    (dl),
        .i_flux  (i_s_tdata[10*VB +: VB]),
        .i_cw    (i_s_tdata[11*VB +: WW]),
        .o_vld   (f_vld),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    tvdllfw_div #(.VALUE_BITS(VB), .NUMW(NUMW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_vld   (d_vld),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    tvdllfw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (d_vld),
        .i_q      (d_q),
        .i_side   (d_side),
        .i_gain   (r_gain),
        .o_vld    (o_m_tvalid),
        .o_weight (b_w),
        .o_lim    (b_l)
    );

    assign o_m_tdata = {6'd0, b_l, b_w};

`ifndef ASSERT_OFF
    a_lim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (b_l <= tvdllfw_pkg::WGT_ONE))
        else $error("limiter value above one");
    a_wgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (b_w <= tvdllfw_pkg::WGT_ONE))
        else $error("face weight above one");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while output stalled");
`endif
endmodule

// ===== sv/tvdllfw_front.sv =====
// Front end: upwind gradient selection, dot product, saturation test and
// signed numerator of the TVD ratio. Depends on tvdllfw_pkg.
module tvdllfw_front #(
    parameter int VALUE_BITS = tvdllfw_pkg::VALUE_BITS_DEF,
    parameter int NUMW = 2 * VALUE_BITS + 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic signed [VALUE_BITS-1:0]        i_step,
    input  logic signed [VALUE_BITS-1:0]        i_go [3],
    input  logic signed [VALUE_BITS-1:0]        i_gn [3],
    input  logic signed [VALUE_BITS-1:0]        i_dl [3],
    input  logic signed [VALUE_BITS-1:0]        i_flux,
    input  logic [tvdllfw_pkg::WGT_W-1:0]       i_cw,
    output logic                                o_vld,
    output logic [NUMW-1:0]                     o_num,
    output logic [VALUE_BITS-1:0]               o_den,
    output tvdllfw_pkg::t_side                  o_side
);
    localparam int PW  = 2 * VALUE_BITS;
    localparam int CW  = 2 * VALUE_BITS + 2;
    localparam int TW  = VALUE_BITS + 26;
    localparam int NW1 = NUMW + 1;

    logic                         r_v1, r_v2, r_v3;
    logic signed [PW-1:0]         r_p [3];
    logic signed [VALUE_BITS-1:0] r_s1, r_s2;
    logic [VALUE_BITS-1:0]        r_sm1, r_sm2, r_sm3;
    logic                         r_up1, r_up2;
    logic [tvdllfw_pkg::WGT_W-1:0] r_cw1, r_cw2;
    logic signed [CW-1:0]         r_c;
    logic [TW-1:0]                r_thr;
    logic [NUMW-1:0]              r_num;
    tvdllfw_pkg::t_side           r_side;

    logic                         n_owner_up;
    logic signed [CW-1:0]         n_cmag_s;
    logic [CW-1:0]                n_cmag;
    logic signed [NW1-1:0]        n_num;
    logic signed [NW1-1:0]        n_nmag;

    assign n_owner_up = (i_flux > 0);
    assign n_cmag_s   = (r_c < 0) ? -r_c : r_c;
    assign n_cmag     = n_cmag_s;
    assign n_num      = (NW1'(r_c) <<< 1) - (NW1'(r_s2) <<< 16);
    assign n_nmag     = (n_num < 0) ? -n_num : n_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= PW'(i_dl[k]) * PW'(n_owner_up ? i_go[k] : i_gn[k]);
            end
            r_s1  <= i_step;
            r_sm1 <= (i_step < 0) ? VALUE_BITS'(-i_step) : VALUE_BITS'(i_step);
            r_up1 <= !(i_flux < 0);
            r_cw1 <= (i_cw > tvdllfw_pkg::WGT_ONE) ? tvdllfw_pkg::WGT_ONE : i_cw;

            r_c   <= CW'(r_p[0]) + CW'(r_p[1]) + CW'(r_p[2]);
            r_thr <= TW'(r_sm1) * TW'(tvdllfw_pkg::SAT_SCALE);
            r_s2  <= r_s1;
            r_sm2 <= r_sm1;
            r_up2 <= r_up1;
            r_cw2 <= r_cw1;

            r_num          <= n_nmag[NUMW-1:0];
            r_sm3          <= r_sm2;
            r_side.sat     <= (n_cmag >= CW'(r_thr));
            r_side.sat_pos <= ((r_c < 0) == (r_s2 < 0));
            r_side.qneg    <= ((n_num < 0) != (r_s2 < 0));
            r_side.up      <= r_up2;
            r_side.cw      <= r_cw2;
        end
    end

    assign o_vld  = r_v3;
    assign o_num  = r_num;
    assign o_den  = r_sm3;
    assign o_side = r_side;
endmodule

// ===== sv/tvdllfw_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tvdllfw_pkg for the quotient width and side record.
module tvdllfw_div #(
    parameter int VALUE_BITS = tvdllfw_pkg::VALUE_BITS_DEF,
    parameter int NUMW = 2 * VALUE_BITS + 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [NUMW-1:0]                  i_num,
    input  logic [VALUE_BITS-1:0]            i_den,
    input  tvdllfw_pkg::t_side               i_side,
    output logic                             o_vld,
    output logic [tvdllfw_pkg::QBITS-1:0]    o_q,
    output tvdllfw_pkg::t_side               o_side
);
    localparam int QB = tvdllfw_pkg::QBITS;
    localparam int RW = VALUE_BITS + 1;

    logic                  r_vld  [QB+1];
    logic [RW-1:0]         r_rem  [QB+1];
    logic [QB-1:0]         r_lq   [QB+1];
    logic [VALUE_BITS-1:0] r_den  [QB+1];
    tvdllfw_pkg::t_side    r_side [QB+1];

    assign r_vld[0]  = i_vld;
    assign r_rem[0]  = RW'(i_num[NUMW-1:QB]);
    assign r_lq[0]   = i_num[QB-1:0];
    assign r_den[0]  = i_den;
    assign r_side[0] = i_side;

    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic [RW:0] n_t;
        logic        n_ge;
        assign n_t  = {r_rem[g], r_lq[g][QB-1]};
        assign n_ge = (n_t >= (RW+1)'(r_den[g]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= n_ge ? RW'(n_t - (RW+1)'(r_den[g])) : RW'(n_t);
                r_lq[g+1]   <= {r_lq[g][QB-2:0], n_ge};
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_vld  = r_vld[QB];
    assign o_q    = r_lq[QB];
    assign o_side = r_side[QB];
endmodule

// ===== sv/tvdllfw_back.sv =====
// Back end: signed ratio, gain product, limiter clamp and weight blend.
// Depends on tvdllfw_pkg.
module tvdllfw_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [tvdllfw_pkg::QBITS-1:0]     i_q,
    input  tvdllfw_pkg::t_side                i_side,
    input  logic [tvdllfw_pkg::GAIN_W-1:0]    i_gain,
    output logic                              o_vld,
    output logic [tvdllfw_pkg::WGT_W-1:0]     o_weight,
    output logic [tvdllfw_pkg::WGT_W-1:0]     o_lim
);
    localparam int RQ = tvdllfw_pkg::RQ_W;
    localparam int PW = RQ + tvdllfw_pkg::GAIN_W + 1;
    localparam int WW = tvdllfw_pkg::WGT_W;
    localparam int AW = 2 * WW + 1;

    logic                   r_v1, r_v2;
    logic signed [PW-1:0]   r_p;
    logic                   r_up;
    logic [WW-1:0]          r_cw;
    logic [WW-1:0]          r_w, r_l;

    logic signed [RQ-1:0]   n_rq;
    logic signed [PW-1:0]   n_sh;
    logic [WW-1:0]          n_lim;
    logic [AW-1:0]          n_acc;

    always_comb begin
        if (i_side.sat) begin
            n_rq = i_side.sat_pos ? tvdllfw_pkg::RQ_SAT_POS : tvdllfw_pkg::RQ_SAT_NEG;
        end else if (i_side.qneg) begin
            n_rq = -RQ'(i_q);
        end else begin
            n_rq = RQ'(i_q);
        end
    end

    assign n_sh = r_p >>> 16;

    always_comb begin
        if (r_p <= 0) begin
            n_lim = '0;
        end else if (n_sh > PW'(tvdllfw_pkg::WGT_ONE)) begin
            n_lim = tvdllfw_pkg::WGT_ONE;
        end else begin
            n_lim = n_sh[WW-1:0];
        end
        n_acc = AW'(n_lim) * AW'(r_cw) + AW'(32768);
        if (r_up) begin
            n_acc = n_acc + (AW'(tvdllfw_pkg::WGT_ONE - n_lim) << 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= PW'(n_rq) * $signed({1'b0, i_gain});
            r_up <= i_side.up;
            r_cw <= i_side.cw;
            r_w  <= n_acc[16+WW-1:16];
            r_l  <= n_lim;
        end
    end

    assign o_vld    = r_v2;
    assign o_weight = r_w;
    assign o_lim    = r_l;
endmodule
